FILE: rtl/core/gtp_pkg.sv
// Package with types, constants and codes shared by the guillotine packer.
package gtp_pkg;

  localparam int MaxFreeCells = 64;
  localparam int AddrW        = $clog2(MaxFreeCells);
  localparam int CntW         = $clog2(MaxFreeCells + 1);
  localparam int DimW         = 13;
  localparam int NeedW        = DimW + 1;
  localparam int MarginW      = 8;

  typedef struct packed {
    logic [DimW-1:0] x;
    logic [DimW-1:0] y;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
  } cell_t;

  typedef enum logic [1:0] {
    STATUS_PLACED = 2'd0,
    STATUS_NOFIT  = 2'd1,
    STATUS_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_SHEET_W = 2'd0,
    CFG_SHEET_H = 2'd1,
    CFG_MARGIN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RD    = 9'b000000010,
    ST_CMP   = 9'b000000100,
    ST_CHK   = 9'b000001000,
    ST_SH_RD = 9'b000010000,
    ST_SH_WR = 9'b000100000,
    ST_PUSHL = 9'b001000000,
    ST_PUSHR = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    cell_t             wdata;
    logic [AddrW-1:0]  raddr;
  } mem_req_t;

endpackage

FILE: rtl/core/gtp_cell_mem.sv
// Free-cell store: one write port and one registered read port.
module gtp_cell_mem
  import gtp_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output cell_t    rdata
);

  cell_t mem [MaxFreeCells];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

FILE: rtl/core/guillotine_rect_packer.sv
// Top level of the guillotine rectangle packer with its placement sequencer.
//
// Each input beat carries one rectangle; one output beat returns its status
// and position. The free cells are kept as a stack in a 64-entry memory with
// the newest cell on top. A placement reads the whole stack through the
// single memory read port, keeping the best fitting cell. It then closes the
// gap left by the picked cell, shifting down each cell above it, and pushes
// up to two cut cells. in_tready is high only while the sequencer is idle.
// A finished result sits in the output register; the sequencer waits there
// while the receiver stalls and resumes once the beat is taken. Reset empties
// the free list and restores the sheet to 1024 by 1024 with no margin.
// Configuration must be written only while no item is in flight.
module guillotine_rect_packer
  import gtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // rect_width[12:0], rect_height[25:13]
  input  logic        in_tuser,   // new_layout
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pos_x[12:0], pos_y[25:13]
  output logic [1:0]  out_tuser   // status
);

  state_t            state_r;
  logic [DimW-1:0]   sheet_w_r, sheet_h_r;
  logic [MarginW-1:0] margin_r;
  logic [CntW-1:0]   count_r, scan_r, j_r, wp_r;
  logic [AddrW-1:0]  pick_r;
  logic              found_r;
  cell_t             pick_c_r;
  logic [NeedW-1:0]  need_w_r, need_h_r;
  status_t           status_r;
  logic              out_valid_r;
  logic [DimW-1:0]   out_x_r, out_y_r;
  status_t           out_status_r;
  mem_req_t          req;
  cell_t             rdata;

  gtp_cell_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

  logic              accept;
  logic              fits, better, cut_low, cut_right;
  logic [NeedW-1:0]  pad2;
  logic [CntW:0]     grow;
  cell_t             right_c, low_c;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign pad2      = {5'd0, margin_r, 1'b0};
  assign fits      = ({1'b0, rdata.w} >= need_w_r) && ({1'b0, rdata.h} >= need_h_r);
  assign better    = !found_r || (rdata.w < pick_c_r.w) || (rdata.h < pick_c_r.h);
  assign cut_low   = {1'b0, pick_c_r.h} > need_h_r;
  assign cut_right = {1'b0, pick_c_r.w} > need_w_r;
  assign grow      = {1'b0, count_r} + {{CntW{1'b0}}, cut_low} + {{CntW{1'b0}}, cut_right};

  always_comb begin
    right_c.x = pick_c_r.x + need_w_r[DimW-1:0];
    right_c.y = pick_c_r.y;
    right_c.w = pick_c_r.w - need_w_r[DimW-1:0];
    right_c.h = cut_low ? need_h_r[DimW-1:0] : pick_c_r.h;
    low_c.x   = pick_c_r.x;
    low_c.y   = pick_c_r.y + need_h_r[DimW-1:0];
    low_c.w   = pick_c_r.w;
    low_c.h   = pick_c_r.h - need_h_r[DimW-1:0];
  end

  always_comb begin
    req.we    = 1'b0;
    req.waddr = wp_r[AddrW-1:0];
    req.wdata = rdata;
    req.raddr = '0;
    unique case (state_r)
      ST_IDLE: begin
        req.we    = accept && in_tuser;
        req.waddr = '0;
        req.wdata = '{x: '0, y: '0, w: sheet_w_r, h: sheet_h_r};
      end
      ST_RD:    req.raddr = scan_r[AddrW-1:0] - AddrW'(1);
      ST_SH_RD: req.raddr = j_r[AddrW-1:0] + AddrW'(1);
      ST_SH_WR: begin
        req.we    = 1'b1;
        req.waddr = j_r[AddrW-1:0];
      end
      ST_PUSHL: begin
        req.we    = cut_low;
        req.wdata = low_c;
      end
      ST_PUSHR: begin
        req.we    = cut_right;
        req.wdata = right_c;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      sheet_w_r   <= DimW'(1024);
      sheet_h_r   <= DimW'(1024);
      margin_r    <= '0;
      found_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SHEET_W: sheet_w_r <= cfg_data;
          CFG_SHEET_H: sheet_h_r <= cfg_data;
          CFG_MARGIN:  margin_r  <= cfg_data[MarginW-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            need_w_r <= {1'b0, in_tdata[12:0]} + pad2;
            need_h_r <= {1'b0, in_tdata[25:13]} + pad2;
            found_r  <= 1'b0;
            pick_r   <= '0;
            if (in_tuser) begin
              count_r <= CntW'(1);
              scan_r  <= CntW'(1);
              state_r <= ST_RD;
            end else if (count_r == '0) begin
              status_r <= STATUS_NOFIT;
              wp_r     <= count_r;
              state_r  <= ST_FIN;
            end else begin
              scan_r  <= count_r;
              state_r <= ST_RD;
            end
          end
        end
        ST_RD: state_r <= ST_CMP;
        ST_CMP: begin
          if (fits && better) begin
            found_r  <= 1'b1;
            pick_r   <= scan_r[AddrW-1:0] - AddrW'(1);
            pick_c_r <= rdata;
          end
          scan_r  <= scan_r - CntW'(1);
          state_r <= (scan_r == CntW'(1)) ? ST_CHK : ST_RD;
        end
        ST_CHK: begin
          wp_r <= count_r;
          if (!found_r) begin
            status_r <= STATUS_NOFIT;
            state_r  <= ST_FIN;
          end else if (grow > (CntW+1)'(MaxFreeCells + 1)) begin
            status_r <= STATUS_FULL;
            state_r  <= ST_FIN;
          end else begin
            status_r <= STATUS_PLACED;
            j_r      <= {1'b0, pick_r};
            state_r  <= ST_SH_RD;
          end
        end
        ST_SH_RD: begin
          if (j_r + CntW'(1) < count_r) begin
            state_r <= ST_SH_WR;
          end else begin
            wp_r    <= count_r - CntW'(1);
            state_r <= ST_PUSHL;
          end
        end
        ST_SH_WR: begin
          j_r     <= j_r + CntW'(1);
          state_r <= ST_SH_RD;
        end
        ST_PUSHL: begin
          if (cut_low) wp_r <= wp_r + CntW'(1);
          state_r <= ST_PUSHR;
        end
        ST_PUSHR: begin
          if (cut_right) wp_r <= wp_r + CntW'(1);
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_x_r      <= (status_r == STATUS_PLACED) ?
                            pick_c_r.x + {5'd0, margin_r} : '0;
            out_y_r      <= (status_r == STATUS_PLACED) ?
                            pick_c_r.y + {5'd0, margin_r} : '0;
            count_r      <= wp_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_y_r, out_x_r};
  assign out_tuser  = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MaxFreeCells))
    else $error("free cell count above table depth");

  a_placed_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && status_r == STATUS_PLACED) |-> found_r)
    else $error("placement without a picked cell");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input taken again before the item finished");

  a_push_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSHL || state_r == ST_PUSHR) |-> wp_r < CntW'(MaxFreeCells) ||
    (state_r == ST_PUSHL && !cut_low) || (state_r == ST_PUSHR && !cut_right))
    else $error("cell push beyond table depth");

endmodule

FILE: tb/guillotine_rect_packer_tb.sv
// Self-checking testbench for the guillotine rectangle packer, with a placement predictor.
module guillotine_rect_packer_tb;
  import gtp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    int unsigned x, y, w, h;
  } free_rect_t;

  typedef struct {
    status_t      status;
    logic [12:0]  pos_x;
    logic [12:0]  pos_y;
  } placement_t;

  class placement_board;
    free_rect_t  cells[MaxFreeCells];
    int unsigned num_cells;
    int unsigned sheet_w = 1024, sheet_h = 1024, pad = 0;
    placement_t  pending[$];
    int          errors = 0;

    function void place(bit new_layout, int unsigned rw, int unsigned rh);
      placement_t  res;
      free_rect_t  cut[MaxFreeCells + 2];
      free_rect_t  c;
      int unsigned need_w, need_h, pick, n;
      bit          found, cut_low;
      res.status = STATUS_NOFIT;
      res.pos_x  = '0;
      res.pos_y  = '0;
      found = 0;
      pick  = 0;
      n     = 0;
      if (new_layout) begin
        cells[0] = '{0, 0, sheet_w, sheet_h};
        num_cells = 1;
      end
      need_w = rw + 2 * pad;
      need_h = rh + 2 * pad;
      for (int i = 0; i < num_cells; i++) begin
        if (cells[i].w >= need_w && cells[i].h >= need_h &&
            (!found || cells[i].w < cells[pick].w || cells[i].h < cells[pick].h)) begin
          pick  = i;
          found = 1;
        end
      end
      if (found) begin
        c = cells[pick];
        cut_low = c.h > need_h;
        if (c.w > need_w) begin
          cut[n] = '{c.x + need_w, c.y, c.w - need_w, cut_low ? need_h : c.h};
          n++;
        end
        if (cut_low) begin
          cut[n] = '{c.x, c.y + need_h, c.w, c.h - need_h};
          n++;
        end
        if (num_cells - 1 + n > MaxFreeCells) begin
          res.status = STATUS_FULL;
        end else begin
          for (int i = 0; i < num_cells; i++) begin
            if (i != pick) begin
              cut[n] = cells[i];
              n++;
            end
          end
          for (int i = 0; i < n; i++) cells[i] = cut[i];
          num_cells  = n;
          res.status = STATUS_PLACED;
          res.pos_x  = 13'(c.x + pad);
          res.pos_y  = 13'(c.y + pad);
        end
      end
      pending.push_back(res);
    endfunction

    function void check(logic [1:0] status, logic [12:0] px, logic [12:0] py);
      placement_t exp_res;
      if (pending.size() == 0) begin
        $error("result beat with no placement pending");
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (status !== exp_res.status) begin
        $error("status expected %0d actual %0d", exp_res.status, status);
        errors++;
      end
      if (px !== exp_res.pos_x) begin
        $error("pos_x expected %0d actual %0d", exp_res.pos_x, px);
        errors++;
      end
      if (py !== exp_res.pos_y) begin
        $error("pos_y expected %0d actual %0d", exp_res.pos_y, py);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  placement_board board = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 0;

  guillotine_rect_packer dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check(out_tuser, out_tdata[12:0], out_tdata[25:13]);
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 0;
        repeat (3000) @(negedge clk);
        hold_req = 0;
      end
      out_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [12:0] val);
    @(negedge clk);
    cfg_we    = 1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      CFG_SHEET_W: board.sheet_w = val;
      CFG_SHEET_H: board.sheet_h = val;
      default:     board.pad = val[7:0];
    endcase
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic send_rect(bit new_layout, logic [12:0] rw, logic [12:0] rh);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    in_tvalid = 1;
    in_tuser  = new_layout;
    in_tdata  = {6'b0, rh, rw};
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    board.place(new_layout, rw, rh);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    int unsigned sw[6] = '{1024, 4096, 1, 4096, 0, 8191};
    int unsigned sh[6] = '{1024, 4096, 4096, 1, 8191, 0};
    int unsigned mg[6] = '{0, 0, 255, 1, 3, 0};
    int unsigned rw, rh, pick;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed beats: empty list, zero size, extremes, exact fit, margins.
    send_rect(0, 5, 5);
    send_rect(1, 0, 0);
    send_rect(0, 0, 0);
    send_rect(1, 8191, 8191);
    send_rect(0, 8191, 1);
    send_rect(1, 1024, 1024);
    send_rect(0, 1, 1);
    send_rect(1, 4096, 4096);
    send_rect(1, 1000, 24);
    send_rect(0, 24, 1000);
    send_rect(0, 24, 24);
    send_rect(0, 1, 1);
    drain();
    write_reg(CFG_MARGIN, 255);
    send_rect(1, 0, 0);
    send_rect(0, 514, 0);
    send_rect(0, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_SHEET_W, sw[ph]);
      write_reg(CFG_SHEET_H, sh[ph]);
      write_reg(CFG_MARGIN, mg[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      for (int k = 0; k < 290; k++) begin
        if (ph == 0 && k == 40) hold_req = 1;
        pick = $urandom_range(0, 99);
        if (pick < 88) begin
          rw = $urandom_range(0, 64);
          rh = $urandom_range(0, 64);
        end else if (pick < 94) begin
          rw = $urandom_range(0, 4096);
          rh = $urandom_range(0, 4096);
        end else begin
          rw = $urandom_range(0, 8191);
          rh = $urandom_range(0, 8191);
        end
        send_rect(k == 0 || $urandom_range(0, 79) == 0, rw, rh);
      end
      drain();
    end

    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
